@@ design/bdq_pkg.sv @@
// Shared types and constants for the band dwell qualifier.
// Used by bdq_step, band_dwell_qualifier_core and the testbench; depends on nothing else.
`timescale 1ns / 1ps

package bdq_pkg;

    // Default field widths
    localparam int TIME_BITS_DEFAULT = 48;
    localparam int TEMP_BITS_DEFAULT = 16;

    // Register port geometry: eight registers at 8-byte spacing
    localparam int APB_ADDR_BITS = 6;
    localparam int APB_DATA_BITS = 64;
    localparam int REG_IDX_BITS  = 3;

    localparam int BAND_WIDTH_RESET   = 256;
    localparam int BAND_CEILING_RESET = 32767;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_TARGET_TEMP   = 3'd0,
        REG_BAND_WIDTH    = 3'd1,
        REG_BAND_FLOOR    = 3'd2,
        REG_BAND_CEILING  = 3'd3,
        REG_REQUIRED_MS   = 3'd4,
        REG_GRACE_MS      = 3'd5,
        REG_MAX_GAP_MS    = 3'd6,
        REG_SENSOR_CHOICE = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        PR_INVALID  = 3'd0,
        PR_UNAVAIL  = 3'd1,
        PR_OUTSIDE  = 3'd2,
        PR_GRACE    = 3'd3,
        PR_INBAND   = 3'd4,
        PR_COMPLETE = 3'd5
    } t_progress;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNAVAIL = 2'd1,
        ST_INVALID = 2'd2,
        ST_RSVD    = 2'd3
    } t_status;

    localparam logic PHASE_PREHEAT = 1'b0;
    localparam logic SENSOR_AIR    = 1'b0;

endpackage

@@ design/bdq_step.sv @@
// Single-pass episode update for one sample pair: band test, gap and grace
// checks, credit accumulation. Purely combinational; depends on bdq_pkg.
`timescale 1ns / 1ps

module bdq_step #(
    parameter int TIME_BITS = bdq_pkg::TIME_BITS_DEFAULT,
    parameter int TEMP_BITS = bdq_pkg::TEMP_BITS_DEFAULT
) (
    // configuration
    input  logic signed [TEMP_BITS-1:0] i_target_temp,
    input  logic [TEMP_BITS-2:0]        i_band_width,
    input  logic [TEMP_BITS-2:0]        i_band_floor,
    input  logic [TEMP_BITS-2:0]        i_band_ceiling,
    input  logic [TIME_BITS-1:0]        i_required_ms,
    input  logic [TIME_BITS-1:0]        i_grace_ms,
    input  logic [TIME_BITS-1:0]        i_max_gap_ms,
    input  logic                        i_sensor_choice,
    // item
    input  logic [1:0]                  i_phase,
    input  logic [TIME_BITS-1:0]        i_sample_time_ms,
    input  logic                        i_timing_known,
    input  logic [1:0]                  i_air_status,
    input  logic signed [TEMP_BITS-1:0] i_air_temp,
    input  logic [1:0]                  i_product_status,
    input  logic signed [TEMP_BITS-1:0] i_product_temp,
    // current episode
    input  logic                        i_last_phase,
    input  logic                        i_episode_active,
    input  logic [TIME_BITS-1:0]        i_credited_time,
    input  logic [TIME_BITS-1:0]        i_last_usable_time,
    input  logic                        i_last_usable_valid,
    input  logic [TIME_BITS-1:0]        i_grace_start_time,
    input  logic                        i_grace_active,
    // next episode
    output logic                        o_last_phase,
    output logic                        o_episode_active,
    output logic [TIME_BITS-1:0]        o_credited_time,
    output logic [TIME_BITS-1:0]        o_last_usable_time,
    output logic                        o_last_usable_valid,
    output logic [TIME_BITS-1:0]        o_grace_start_time,
    output logic                        o_grace_active,
    // result
    output logic [2:0]                  o_progress,
    output logic                        o_applicable
);

    localparam bit WRAP_AT_TOP = (TIME_BITS == 64);

    logic                        phase_change;
    logic                        cur_ep;
    logic [TIME_BITS-1:0]        cur_cred;
    logic [TIME_BITS-1:0]        cur_lut;
    logic                        cur_luv;
    logic [TIME_BITS-1:0]        cur_gs;
    logic                        cur_grace;
    logic                        use_air;
    logic [1:0]                  status;
    logic signed [TEMP_BITS-1:0] meas;
    logic signed [TEMP_BITS:0]   dev;
    logic [TEMP_BITS:0]          mag;
    logic                        in_band;
    logic                        band_bad;
    logic [TIME_BITS-1:0]        since_usable;
    logic [TIME_BITS-1:0]        since_grace;
    logic                        gap_bad;
    logic [TIME_BITS:0]          sum;
    logic                        sum_ovf;
    logic                        sum_reached;
    bdq_pkg::t_progress          prog;

    // A phase change starts evaluation from a cleared episode
    assign phase_change = (i_phase[0] != i_last_phase);
    assign cur_ep    = phase_change ? 1'b0 : i_episode_active;
    assign cur_cred  = phase_change ? '0   : i_credited_time;
    assign cur_lut   = phase_change ? '0   : i_last_usable_time;
    assign cur_luv   = phase_change ? 1'b0 : i_last_usable_valid;
    assign cur_gs    = phase_change ? '0   : i_grace_start_time;
    assign cur_grace = phase_change ? 1'b0 : i_grace_active;

    assign use_air = (i_phase[0] == bdq_pkg::PHASE_PREHEAT)
                  || (i_sensor_choice == bdq_pkg::SENSOR_AIR);
    assign status  = use_air ? i_air_status : i_product_status;
    assign meas    = use_air ? i_air_temp : i_product_temp;

    assign dev     = (TEMP_BITS+1)'(meas) - (TEMP_BITS+1)'(i_target_temp);
    assign mag     = dev[TEMP_BITS] ? (TEMP_BITS+1)'(-dev) : (TEMP_BITS+1)'(dev);
    assign in_band = (mag <= {2'b00, i_band_width});

    assign band_bad = (i_band_width < i_band_floor) || (i_band_width > i_band_ceiling);

    assign since_usable = i_sample_time_ms - cur_lut;
    assign since_grace  = i_sample_time_ms - cur_gs;
    assign gap_bad = cur_luv && ((i_sample_time_ms < cur_lut) || (since_usable > i_max_gap_ms));

    assign sum = {1'b0, cur_cred} + {1'b0, (cur_luv ? since_usable : {TIME_BITS{1'b0}})};
    assign sum_ovf     = WRAP_AT_TOP && sum[TIME_BITS];
    assign sum_reached = (sum >= {1'b0, i_required_ms});

    always_comb begin
        // Default: cleared episode, invalid result
        o_last_phase        = i_last_phase;
        o_episode_active    = 1'b0;
        o_credited_time     = '0;
        o_last_usable_time  = '0;
        o_last_usable_valid = 1'b0;
        o_grace_start_time  = '0;
        o_grace_active      = 1'b0;
        o_applicable        = 1'b1;
        prog                = bdq_pkg::PR_INVALID;

        if (i_phase[1]) begin
            o_applicable = 1'b0;
        end else begin
            o_last_phase = i_phase[0];
            if (band_bad || (i_required_ms == '0)) begin
                prog = bdq_pkg::PR_INVALID;
            end else if (!i_timing_known) begin
                prog = bdq_pkg::PR_UNAVAIL;
            end else if (i_max_gap_ms == '0) begin
                prog = bdq_pkg::PR_INVALID;
            end else if (status == bdq_pkg::ST_UNAVAIL) begin
                prog = bdq_pkg::PR_UNAVAIL;
            end else if (status != bdq_pkg::ST_OK) begin
                prog = bdq_pkg::PR_INVALID;
            end else if (gap_bad) begin
                prog = bdq_pkg::PR_INVALID;
            end else if (cur_grace) begin
                if (i_sample_time_ms < cur_gs) begin
                    prog = bdq_pkg::PR_INVALID;
                end else if (since_grace >= i_grace_ms) begin
                    // grace ran out: restart if back in band
                    if (!in_band) begin
                        prog = bdq_pkg::PR_OUTSIDE;
                    end else begin
                        o_episode_active    = 1'b1;
                        o_last_usable_time  = i_sample_time_ms;
                        o_last_usable_valid = 1'b1;
                        prog                = bdq_pkg::PR_INBAND;
                    end
                end else begin
                    o_episode_active    = cur_ep;
                    o_credited_time     = cur_cred;
                    o_last_usable_time  = i_sample_time_ms;
                    o_last_usable_valid = 1'b1;
                    if (in_band) begin
                        prog = bdq_pkg::PR_INBAND;
                    end else begin
                        o_grace_active     = 1'b1;
                        o_grace_start_time = cur_gs;
                        prog               = bdq_pkg::PR_GRACE;
                    end
                end
            end else if (!in_band) begin
                if (!cur_ep || (i_grace_ms == '0)) begin
                    prog = bdq_pkg::PR_OUTSIDE;
                end else begin
                    o_episode_active    = 1'b1;
                    o_credited_time     = cur_cred;
                    o_grace_active      = 1'b1;
                    o_grace_start_time  = i_sample_time_ms;
                    o_last_usable_time  = i_sample_time_ms;
                    o_last_usable_valid = 1'b1;
                    prog                = bdq_pkg::PR_GRACE;
                end
            end else if (!cur_ep) begin
                o_episode_active    = 1'b1;
                o_last_usable_time  = i_sample_time_ms;
                o_last_usable_valid = 1'b1;
                prog                = bdq_pkg::PR_INBAND;
            end else if (sum_ovf) begin
                prog = bdq_pkg::PR_INVALID;
            end else begin
                o_episode_active    = 1'b1;
                o_credited_time     = sum_reached ? i_required_ms : sum[TIME_BITS-1:0];
                o_last_usable_time  = i_sample_time_ms;
                o_last_usable_valid = 1'b1;
                prog = sum_reached ? bdq_pkg::PR_COMPLETE : bdq_pkg::PR_INBAND;
            end
        end
    end

    assign o_progress = prog;

endmodule

@@ design/band_dwell_qualifier_core.sv @@
// Top level of the band dwell qualifier: register port, item pipeline and
// episode state. Depends on bdq_pkg and bdq_step.
`timescale 1ns / 1ps

// Judges timestamped air/product sample pairs against a temperature band and
// reports how long the judged sample has stayed in band. One item is accepted
// per cycle, sustained, while the result side does not stall. The item is
// captured in an input register, evaluated in one combinational pass against
// the episode registers, and the result lands in the output register while the
// episode registers update on the same edge, so the next item sees the new
// episode at once. A stall on the result side holds the output register and,
// once the input register is also full, raises the input stall. The episode is
// cleared by reset and by any register write; write registers only while no
// item is in flight. There is no clearing pass after reset.
module band_dwell_qualifier_core #(
    parameter int TIME_BITS = bdq_pkg::TIME_BITS_DEFAULT,
    parameter int TEMP_BITS = bdq_pkg::TEMP_BITS_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // register port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bdq_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [bdq_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [bdq_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                               pready,
    // item input
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_phase,
    input  logic [TIME_BITS-1:0]               i_sample_time_ms,
    input  logic                               i_timing_known,
    input  logic [1:0]                         i_air_status,
    input  logic signed [TEMP_BITS-1:0]        i_air_temp,
    input  logic [1:0]                         i_product_status,
    input  logic signed [TEMP_BITS-1:0]        i_product_temp,
    // result output
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [2:0]                         o_progress,
    output logic [TIME_BITS-1:0]               o_credited_ms,
    output logic                               o_applicable
);

    localparam int ADDR_LSB = $clog2(bdq_pkg::APB_DATA_BITS / 8);

    // Configuration registers
    logic [TEMP_BITS-1:0] r_target_temp;
    logic [TEMP_BITS-2:0] r_band_width;
    logic [TEMP_BITS-2:0] r_band_floor;
    logic [TEMP_BITS-2:0] r_band_ceiling;
    logic [TIME_BITS-1:0] r_required_ms;
    logic [TIME_BITS-1:0] r_grace_ms;
    logic [TIME_BITS-1:0] r_max_gap_ms;
    logic                 r_sensor_choice;

    // Episode state
    logic                 r_last_phase;
    logic                 r_episode_active;
    logic [TIME_BITS-1:0] r_credited_time;
    logic [TIME_BITS-1:0] r_last_usable_time;
    logic                 r_last_usable_valid;
    logic [TIME_BITS-1:0] r_grace_start_time;
    logic                 r_grace_active;

    logic                 n_last_phase;
    logic                 n_episode_active;
    logic [TIME_BITS-1:0] n_credited_time;
    logic [TIME_BITS-1:0] n_last_usable_time;
    logic                 n_last_usable_valid;
    logic [TIME_BITS-1:0] n_grace_start_time;
    logic                 n_grace_active;

    // Input register
    logic                        r_in_valid;
    logic [1:0]                  r_phase;
    logic [TIME_BITS-1:0]        r_sample_time_ms;
    logic                        r_timing_known;
    logic [1:0]                  r_air_status;
    logic signed [TEMP_BITS-1:0] r_air_temp;
    logic [1:0]                  r_product_status;
    logic signed [TEMP_BITS-1:0] r_product_temp;

    // Output register
    logic                 r_out_valid;
    logic [2:0]           r_progress;
    logic                 r_applicable;
    logic [TIME_BITS-1:0] r_credited_ms;

    logic                 n_applicable;
    logic [2:0]           n_progress;

    logic                 cfg_wr;
    bdq_pkg::t_reg_idx    cfg_idx;
    logic                 advance;
    logic                 in_accept;

    // ---------------------------------------------------------------
    // Register port: zero wait states, write on the access phase
    // ---------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = bdq_pkg::t_reg_idx'(paddr[ADDR_LSB +: bdq_pkg::REG_IDX_BITS]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_temp   <= '0;
            r_band_width    <= (TEMP_BITS-1)'(bdq_pkg::BAND_WIDTH_RESET);
            r_band_floor    <= '0;
            r_band_ceiling  <= (TEMP_BITS-1)'(bdq_pkg::BAND_CEILING_RESET);
            r_required_ms   <= '0;
            r_grace_ms      <= '0;
            r_max_gap_ms    <= '0;
            r_sensor_choice <= 1'b0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                bdq_pkg::REG_TARGET_TEMP:   r_target_temp   <= pwdata[TEMP_BITS-1:0];
                bdq_pkg::REG_BAND_WIDTH:    r_band_width    <= pwdata[TEMP_BITS-2:0];
                bdq_pkg::REG_BAND_FLOOR:    r_band_floor    <= pwdata[TEMP_BITS-2:0];
                bdq_pkg::REG_BAND_CEILING:  r_band_ceiling  <= pwdata[TEMP_BITS-2:0];
                bdq_pkg::REG_REQUIRED_MS:   r_required_ms   <= pwdata[TIME_BITS-1:0];
                bdq_pkg::REG_GRACE_MS:      r_grace_ms      <= pwdata[TIME_BITS-1:0];
                bdq_pkg::REG_MAX_GAP_MS:    r_max_gap_ms    <= pwdata[TIME_BITS-1:0];
                bdq_pkg::REG_SENSOR_CHOICE: r_sensor_choice <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // Read back zero-extended
    always_comb begin
        case (cfg_idx)
            bdq_pkg::REG_TARGET_TEMP:   prdata = bdq_pkg::APB_DATA_BITS'(r_target_temp);
            bdq_pkg::REG_BAND_WIDTH:    prdata = bdq_pkg::APB_DATA_BITS'(r_band_width);
            bdq_pkg::REG_BAND_FLOOR:    prdata = bdq_pkg::APB_DATA_BITS'(r_band_floor);
            bdq_pkg::REG_BAND_CEILING:  prdata = bdq_pkg::APB_DATA_BITS'(r_band_ceiling);
            bdq_pkg::REG_REQUIRED_MS:   prdata = bdq_pkg::APB_DATA_BITS'(r_required_ms);
            bdq_pkg::REG_GRACE_MS:      prdata = bdq_pkg::APB_DATA_BITS'(r_grace_ms);
            bdq_pkg::REG_MAX_GAP_MS:    prdata = bdq_pkg::APB_DATA_BITS'(r_max_gap_ms);
            bdq_pkg::REG_SENSOR_CHOICE: prdata = bdq_pkg::APB_DATA_BITS'(r_sensor_choice);
            default:                    prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Item flow: advance the input register into the result register
    // whenever the result register is empty or being taken.
    // ---------------------------------------------------------------
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_phase          <= i_phase;
            r_sample_time_ms <= i_sample_time_ms;
            r_timing_known   <= i_timing_known;
            r_air_status     <= i_air_status;
            r_air_temp       <= i_air_temp;
            r_product_status <= i_product_status;
            r_product_temp   <= i_product_temp;
        end
    end

    bdq_step #(
        .TIME_BITS (TIME_BITS),
        .TEMP_BITS (TEMP_BITS)
    ) u_step (
        .i_target_temp       (r_target_temp),
        .i_band_width        (r_band_width),
        .i_band_floor        (r_band_floor),
        .i_band_ceiling      (r_band_ceiling),
        .i_required_ms       (r_required_ms),
        .i_grace_ms          (r_grace_ms),
        .i_max_gap_ms        (r_max_gap_ms),
        .i_sensor_choice     (r_sensor_choice),
        .i_phase             (r_phase),
        .i_sample_time_ms    (r_sample_time_ms),
        .i_timing_known      (r_timing_known),
        .i_air_status        (r_air_status),
        .i_air_temp          (r_air_temp),
        .i_product_status    (r_product_status),
        .i_product_temp      (r_product_temp),
        .i_last_phase        (r_last_phase),
        .i_episode_active    (r_episode_active),
        .i_credited_time     (r_credited_time),
        .i_last_usable_time  (r_last_usable_time),
        .i_last_usable_valid (r_last_usable_valid),
        .i_grace_start_time  (r_grace_start_time),
        .i_grace_active      (r_grace_active),
        .o_last_phase        (n_last_phase),
        .o_episode_active    (n_episode_active),
        .o_credited_time     (n_credited_time),
        .o_last_usable_time  (n_last_usable_time),
        .o_last_usable_valid (n_last_usable_valid),
        .o_grace_start_time  (n_grace_start_time),
        .o_grace_active      (n_grace_active),
        .o_progress          (n_progress),
        .o_applicable        (n_applicable)
    );

    // Episode registers: a register write clears the episode but keeps the
    // last phase; otherwise take the new episode with each advancing item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_phase        <= bdq_pkg::PHASE_PREHEAT;
            r_episode_active    <= 1'b0;
            r_credited_time     <= '0;
            r_last_usable_time  <= '0;
            r_last_usable_valid <= 1'b0;
            r_grace_start_time  <= '0;
            r_grace_active      <= 1'b0;
        end else if (cfg_wr) begin
            r_episode_active    <= 1'b0;
            r_credited_time     <= '0;
            r_last_usable_time  <= '0;
            r_last_usable_valid <= 1'b0;
            r_grace_start_time  <= '0;
            r_grace_active      <= 1'b0;
        end else if (advance) begin
            r_last_phase        <= n_last_phase;
            r_episode_active    <= n_episode_active;
            r_credited_time     <= n_credited_time;
            r_last_usable_time  <= n_last_usable_time;
            r_last_usable_valid <= n_last_usable_valid;
            r_grace_start_time  <= n_grace_start_time;
            r_grace_active      <= n_grace_active;
        end
    end

    // Result register: hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_progress    <= n_progress;
            r_applicable  <= n_applicable;
            r_credited_ms <= n_credited_time;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_progress    = r_progress;
    assign o_credited_ms = r_credited_ms;
    assign o_applicable  = r_applicable;

`ifndef SYNTHESIS
    // Grace only runs inside an active episode with a usable time on record
    a_grace_in_episode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_grace_active |-> (r_episode_active && r_last_usable_valid))
        else $error("grace active outside a valid episode");

    // An active episode always has a usable time on record
    a_episode_has_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_episode_active |-> r_last_usable_valid)
        else $error("episode active without last usable time");

    // An empty result register never backs up the input side
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> !o_in_stall)
        else $error("input stalled while result register empty");

    // An inapplicable result is invalid and carries no credit
    a_inapplicable_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_applicable) |->
            ((r_progress == bdq_pkg::PR_INVALID) && (r_credited_ms == '0)))
        else $error("inapplicable item with nonzero result");
`endif

endmodule

@@ tb/tb_band_dwell_qualifier_core.sv @@
// Self-checking testbench for band_dwell_qualifier_core: directed dwell sequences,
// register sweeps and random sample streams, checked against an in-bench predictor.
// Depends on bdq_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_band_dwell_qualifier_core;
    import bdq_pkg::*;

    localparam int          TW             = TIME_BITS_DEFAULT;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          PRINT_CAP      = 60;
    localparam logic [47:0] MAX48          = 48'hFFFF_FFFF_FFFF;

    // Phase codes as carried in the item; 2 and 3 are illegal codes
    localparam logic [1:0] PH_PREHEAT = 2'd0;
    localparam logic [1:0] PH_HOLD    = 2'd1;
    localparam logic [1:0] PH_BAD2    = 2'd2;
    localparam logic [1:0] PH_BAD3    = 2'd3;
    localparam logic       SENSOR_PRODUCT = 1'b1;

    typedef struct packed {
        logic [1:0]        phase;
        logic [TW-1:0]     time_ms;
        logic              timing_known;
        logic [1:0]        air_status;
        logic signed [15:0] air_temp;
        logic [1:0]        product_status;
        logic signed [15:0] product_temp;
    } t_sample;

    typedef struct packed {
        t_progress         progress;
        logic [TW-1:0]     credited_ms;
        logic              applicable;
    } t_verdict;

    // ------------------------------------------------------------------
    // DUT connections
    // ------------------------------------------------------------------
    logic                       i_clk;
    logic                       i_rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [APB_ADDR_BITS-1:0]   paddr;
    logic [APB_DATA_BITS-1:0]   pwdata;
    logic [APB_DATA_BITS-1:0]   prdata;
    logic                       pready;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic [1:0]                 i_phase;
    logic [TW-1:0]              i_sample_time_ms;
    logic                       i_timing_known;
    logic [1:0]                 i_air_status;
    logic signed [15:0]         i_air_temp;
    logic [1:0]                 i_product_status;
    logic signed [15:0]         i_product_temp;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic [2:0]                 o_progress;
    logic [TW-1:0]              o_credited_ms;
    logic                       o_applicable;

    band_dwell_qualifier_core uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_phase          (i_phase),
        .i_sample_time_ms (i_sample_time_ms),
        .i_timing_known   (i_timing_known),
        .i_air_status     (i_air_status),
        .i_air_temp       (i_air_temp),
        .i_product_status (i_product_status),
        .i_product_temp   (i_product_temp),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_progress       (o_progress),
        .o_credited_ms    (o_credited_ms),
        .o_applicable     (o_applicable)
    );

    // ------------------------------------------------------------------
    // Predictor state: register shadow and episode copy
    // ------------------------------------------------------------------
    logic signed [15:0] cfg_target;
    logic [14:0]        cfg_band_width;
    logic [14:0]        cfg_band_floor;
    logic [14:0]        cfg_band_ceiling;
    logic [TW-1:0]      cfg_required_ms;
    logic [TW-1:0]      cfg_grace_ms;
    logic [TW-1:0]      cfg_max_gap_ms;
    logic               cfg_sensor;

    logic               ep_last_phase;
    logic               ep_active;
    logic [TW-1:0]      ep_credit;
    logic [TW-1:0]      ep_last_time;
    logic               ep_last_valid;
    logic [TW-1:0]      ep_grace_start;
    logic               ep_grace_active;

    t_verdict           pending_verdicts[$];
    int                 mismatch_count;
    int                 quiet_cycles;
    bit                 reset_released;

    // Traffic shaping knobs
    int                 in_idle_mode;     // 0 back to back, 1 bursts with gaps
    int                 out_stall_mode;   // 0 never, 1 random, 2 periodic
    int                 burst_left;
    int                 stall_tick;
    logic [TW-1:0]      sample_clock;
    logic               run_phase;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void drop_episode();
        ep_active       = 1'b0;
        ep_credit       = '0;
        ep_last_time    = '0;
        ep_last_valid   = 1'b0;
        ep_grace_start  = '0;
        ep_grace_active = 1'b0;
    endfunction

    function automatic t_verdict verdict(t_progress code, logic appl);
        t_verdict v;
        v.progress    = code;
        v.credited_ms = ep_credit;
        v.applicable  = appl;
        return v;
    endfunction

    function automatic t_verdict abort_episode(t_progress code);
        drop_episode();
        return verdict(code, 1'b1);
    endfunction

    // Judge one sample pair and advance the episode copy
    function automatic t_verdict judge_sample(t_sample s);
        logic [1:0]    st;
        int            meas;
        int            dev;
        logic          in_band;
        logic [TW-1:0] span;
        logic [63:0]   sum;

        if (s.phase > PH_HOLD) begin
            drop_episode();
            return verdict(PR_INVALID, 1'b0);
        end
        // A phase change drops the episode but evaluation goes on
        if (s.phase[0] != ep_last_phase) begin
            drop_episode();
            ep_last_phase = s.phase[0];
        end
        if (cfg_band_width < cfg_band_floor || cfg_band_width > cfg_band_ceiling ||
            cfg_required_ms == 0)
            return abort_episode(PR_INVALID);
        if (!s.timing_known)
            return abort_episode(PR_UNAVAIL);
        if (cfg_max_gap_ms == 0)
            return abort_episode(PR_INVALID);

        // Air rules in preheating or when chosen; product otherwise
        if (s.phase[0] == PHASE_PREHEAT || cfg_sensor == SENSOR_AIR) begin
            st   = s.air_status;
            meas = $signed(s.air_temp);
        end else begin
            st   = s.product_status;
            meas = $signed(s.product_temp);
        end
        if (st == ST_UNAVAIL)
            return abort_episode(PR_UNAVAIL);
        if (st != ST_OK)
            return abort_episode(PR_INVALID);

        dev = meas - int'(cfg_target);
        if (dev < 0)
            dev = -dev;
        in_band = (dev <= int'(cfg_band_width));

        if (ep_last_valid) begin
            span = s.time_ms - ep_last_time;
            if (s.time_ms < ep_last_time || span > cfg_max_gap_ms)
                return abort_episode(PR_INVALID);
        end

        if (ep_grace_active) begin
            if (s.time_ms < ep_grace_start)
                return abort_episode(PR_INVALID);
            span = s.time_ms - ep_grace_start;
            if (span >= cfg_grace_ms) begin
                // Grace ran out: drop the episode either way, restart only if in band
                drop_episode();
                if (!in_band)
                    return verdict(PR_OUTSIDE, 1'b1);
                ep_active     = 1'b1;
                ep_last_time  = s.time_ms;
                ep_last_valid = 1'b1;
                return verdict(PR_INBAND, 1'b1);
            end
            ep_last_time  = s.time_ms;
            ep_last_valid = 1'b1;
            if (in_band) begin
                // Back in band: close grace, credit nothing for the excursion
                ep_grace_active = 1'b0;
                ep_grace_start  = '0;
                return verdict(PR_INBAND, 1'b1);
            end
            return verdict(PR_GRACE, 1'b1);
        end

        if (!in_band) begin
            if (!ep_active || cfg_grace_ms == 0)
                return abort_episode(PR_OUTSIDE);
            ep_grace_active = 1'b1;
            ep_grace_start  = s.time_ms;
            ep_last_time    = s.time_ms;
            ep_last_valid   = 1'b1;
            return verdict(PR_GRACE, 1'b1);
        end

        if (!ep_active) begin
            ep_active     = 1'b1;
            ep_credit     = '0;
            ep_last_time  = s.time_ms;
            ep_last_valid = 1'b1;
            return verdict(PR_INBAND, 1'b1);
        end

        span = ep_last_valid ? s.time_ms - ep_last_time : '0;
        sum  = 64'(ep_credit) + 64'(span);
        ep_credit     = (sum >= 64'(cfg_required_ms)) ? cfg_required_ms : sum[TW-1:0];
        ep_last_time  = s.time_ms;
        ep_last_valid = 1'b1;
        if (ep_credit >= cfg_required_ms)
            return verdict(PR_COMPLETE, 1'b1);
        return verdict(PR_INBAND, 1'b1);
    endfunction

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Result side: stall pattern, driven on the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        stall_tick <= stall_tick + 1;
        if (!reset_released) begin
            i_out_stall <= 1'b0;
        end else begin
            case (out_stall_mode)
                1:       i_out_stall <= ($urandom_range(0, 99) < 35);
                2:       i_out_stall <= ((stall_tick % 13) < 5);
                default: i_out_stall <= 1'b0;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each accepted result with the oldest verdict
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_verdict want;
        if (reset_released && o_out_valid && !i_out_stall) begin
            if (pending_verdicts.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= PRINT_CAP)
                    $display("%0t: result with nothing pending: progress %0d credited %0d",
                             $time, o_progress, o_credited_ms);
            end else begin
                want = pending_verdicts.pop_front();
                if (o_progress !== want.progress) begin
                    mismatch_count++;
                    if (mismatch_count <= PRINT_CAP)
                        $display("%0t: progress expected %0d (%s) actual %0d", $time,
                                 want.progress, want.progress.name(), o_progress);
                end
                if (o_credited_ms !== want.credited_ms) begin
                    mismatch_count++;
                    if (mismatch_count <= PRINT_CAP)
                        $display("%0t: credited_ms expected %0d actual %0d", $time,
                                 want.credited_ms, o_credited_ms);
                end
                if (o_applicable !== want.applicable) begin
                    mismatch_count++;
                    if (mismatch_count <= PRINT_CAP)
                        $display("%0t: applicable expected %0d actual %0d", $time,
                                 want.applicable, o_applicable);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if nothing moves for too long
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (reset_released) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers. Every task starts and ends just after a falling edge.
    // ------------------------------------------------------------------

    // Send one item, honoring the burst/gap pattern, and log its verdict
    task automatic send_sample(t_sample s);
        int gap;
        if (in_idle_mode != 0 && burst_left == 0) begin
            gap        = $urandom_range(1, 8);
            burst_left = $urandom_range(1, 12);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        if (burst_left > 0)
            burst_left--;
        i_phase          <= s.phase;
        i_sample_time_ms <= s.time_ms;
        i_timing_known   <= s.timing_known;
        i_air_status     <= s.air_status;
        i_air_temp       <= s.air_temp;
        i_product_status <= s.product_status;
        i_product_temp   <= s.product_temp;
        i_in_valid       <= 1'b1;
        // Hold the item until the block takes it
        do
            @(posedge i_clk);
        while (o_in_stall);
        pending_verdicts.push_back(judge_sample(s));
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every result is back and the pipe is empty
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Register write: setup phase, access phase, then back to idle
    task automatic write_reg(t_reg_idx idx, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        case (idx)
            REG_TARGET_TEMP:   cfg_target       = value[15:0];
            REG_BAND_WIDTH:    cfg_band_width   = value[14:0];
            REG_BAND_FLOOR:    cfg_band_floor   = value[14:0];
            REG_BAND_CEILING:  cfg_band_ceiling = value[14:0];
            REG_REQUIRED_MS:   cfg_required_ms  = value[TW-1:0];
            REG_GRACE_MS:      cfg_grace_ms     = value[TW-1:0];
            REG_MAX_GAP_MS:    cfg_max_gap_ms   = value[TW-1:0];
            REG_SENSOR_CHOICE: cfg_sensor       = value[0];
            default: ;
        endcase
        drop_episode();
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic apply_setting(int target, int bw, int floor_w, int ceil_w,
                                 logic [TW-1:0] req, logic [TW-1:0] grace,
                                 logic [TW-1:0] max_gap, logic sensor);
        drain_results();
        write_reg(REG_TARGET_TEMP,   64'(target));
        write_reg(REG_BAND_WIDTH,    64'(bw));
        write_reg(REG_BAND_FLOOR,    64'(floor_w));
        write_reg(REG_BAND_CEILING,  64'(ceil_w));
        write_reg(REG_REQUIRED_MS,   64'(req));
        write_reg(REG_GRACE_MS,      64'(grace));
        write_reg(REG_MAX_GAP_MS,    64'(max_gap));
        write_reg(REG_SENSOR_CHOICE, 64'(sensor));
    endtask

    function automatic t_sample mk(logic [1:0] ph, logic [TW-1:0] t, logic tk,
                                   logic [1:0] ast, int atemp, logic [1:0] pst, int ptemp);
        t_sample s;
        s.phase          = ph;
        s.time_ms        = t;
        s.timing_known   = tk;
        s.air_status     = ast;
        s.air_temp       = 16'(atemp);
        s.product_status = pst;
        s.product_temp   = 16'(ptemp);
        return s;
    endfunction

    // Temperature spread around the target, about 1.5 band widths each way
    function automatic logic signed [15:0] near_temp();
        int span;
        int t;
        span = int'(cfg_band_width) + int'(cfg_band_width) / 2 + 2;
        t    = int'(cfg_target) + int'($urandom_range(0, 2 * span)) - span;
        if (t > 32767)
            t = 32767;
        if (t < -32768)
            t = -32768;
        return 16'(t);
    endfunction

    // Random stream: mostly well-formed monotonic sequences near the band,
    // the rest pure noise. Pacing modes are reshuffled every 64 items.
    task automatic random_run(int count, int noise_pct, logic [TW-1:0] step_cap);
        t_sample       s;
        logic [63:0]   r64;
        int            pick;
        for (int k = 0; k < count; k++) begin
            if (k % 64 == 0) begin
                in_idle_mode   = ($urandom_range(0, 2) == 0) ? 0 : 1;
                out_stall_mode = $urandom_range(0, 2);
            end
            if ($urandom_range(0, 99) < noise_pct) begin
                s.phase          = 2'($urandom_range(0, 3));
                s.time_ms        = TW'({$urandom(), $urandom()});
                s.timing_known   = 1'($urandom_range(0, 1));
                s.air_status     = 2'($urandom_range(0, 3));
                s.air_temp       = 16'($urandom());
                s.product_status = 2'($urandom_range(0, 3));
                s.product_temp   = 16'($urandom());
            end else begin
                if ($urandom_range(0, 99) < 3)
                    run_phase = ~run_phase;
                pick = $urandom_range(0, 99);
                r64  = {$urandom(), $urandom()};
                if (pick < 88)
                    sample_clock = sample_clock + TW'(r64 % (64'(step_cap) + 64'd1));
                else if (pick < 94)
                    // gap just past the limit
                    sample_clock = sample_clock + step_cap + TW'(1) +
                                   TW'($urandom_range(0, 50));
                else
                    // time running backwards
                    sample_clock = sample_clock - TW'($urandom_range(1, 50));
                s.phase          = {1'b0, run_phase};
                s.time_ms        = sample_clock;
                s.timing_known   = ($urandom_range(0, 99) >= 3);
                s.air_status     = ($urandom_range(0, 99) < 92) ? ST_OK :
                                   2'($urandom_range(1, 3));
                s.air_temp       = near_temp();
                s.product_status = ($urandom_range(0, 99) < 92) ? ST_OK :
                                   2'($urandom_range(1, 3));
                s.product_temp   = near_temp();
            end
            send_sample(s);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: required_ms is zero, so every legal phase is invalid
    task automatic test_reset_values();
        in_idle_mode   = 1;
        out_stall_mode = 1;
        send_sample(mk(PH_PREHEAT, 48'd10, 1'b1, ST_OK, 0, ST_OK, 0));
        send_sample(mk(PH_HOLD, 48'd20, 1'b1, ST_OK, 0, ST_OK, 0));
        send_sample(mk(PH_BAD2, 48'd30, 1'b1, ST_OK, 0, ST_OK, 0));
        send_sample(mk(PH_PREHEAT, 48'd40, 1'b0, ST_UNAVAIL, 0, ST_OK, 0));
    endtask

    // Walk one episode through credit, completion, grace and the timing, status and gap aborts
    task automatic test_dwell_sequence();
        apply_setting(6400, 256, 16, 4096, 48'd1000, 48'd300, 48'd500, SENSOR_AIR);
        in_idle_mode   = 1;
        out_stall_mode = 2;
        send_sample(mk(PH_PREHEAT, 48'd1000, 1'b1, ST_OK, 6400, ST_OK, -32768));
        send_sample(mk(PH_PREHEAT, 48'd1200, 1'b1, ST_OK, 6656, ST_OK, 32767));  // band edge
        send_sample(mk(PH_PREHEAT, 48'd1500, 1'b1, ST_OK, 6144, ST_OK, 0));
        send_sample(mk(PH_PREHEAT, 48'd1800, 1'b1, ST_OK, 6657, ST_OK, 0));      // opens grace
        send_sample(mk(PH_PREHEAT, 48'd1900, 1'b1, ST_OK, 6400, ST_OK, 0));      // grace ends
        send_sample(mk(PH_PREHEAT, 48'd2300, 1'b1, ST_OK, 6400, ST_OK, 0));
        send_sample(mk(PH_PREHEAT, 48'd2500, 1'b1, ST_OK, 6400, ST_OK, 0));      // capped, complete
        send_sample(mk(PH_PREHEAT, 48'd2600, 1'b1, ST_OK, 6000, ST_OK, 0));
        send_sample(mk(PH_PREHEAT, 48'd2800, 1'b1, ST_OK, 6000, ST_OK, 0));
        send_sample(mk(PH_PREHEAT, 48'd2950, 1'b1, ST_OK, 6400, ST_OK, 0));      // expired, in band
        send_sample(mk(PH_PREHEAT, 48'd3000, 1'b1, ST_OK, 7000, ST_OK, 0));
        send_sample(mk(PH_PREHEAT, 48'd3300, 1'b1, ST_OK, 7000, ST_OK, 0));      // expired, outside
        send_sample(mk(PH_PREHEAT, 48'd3400, 1'b1, ST_OK, 6400, ST_OK, 0));
        send_sample(mk(PH_PREHEAT, 48'd3300, 1'b1, ST_OK, 6400, ST_OK, 0));      // backwards
        send_sample(mk(PH_PREHEAT, 48'd3400, 1'b1, ST_OK, 6400, ST_OK, 0));
        send_sample(mk(PH_PREHEAT, 48'd3901, 1'b1, ST_OK, 6400, ST_OK, 0));      // gap too long
        send_sample(mk(PH_PREHEAT, 48'd4000, 1'b0, ST_OK, 6400, ST_OK, 0));
        send_sample(mk(PH_PREHEAT, 48'd4100, 1'b1, ST_UNAVAIL, 6400, ST_OK, 0));
        send_sample(mk(PH_PREHEAT, 48'd4200, 1'b1, ST_INVALID, 6400, ST_OK, 0));
        send_sample(mk(PH_PREHEAT, 48'd4300, 1'b1, ST_RSVD, 6400, ST_OK, 0));
        send_sample(mk(PH_HOLD, 48'd4400, 1'b1, ST_OK, 6400, ST_INVALID, 0));    // phase change
        send_sample(mk(PH_BAD2, 48'd4500, 1'b1, ST_OK, 6400, ST_OK, 0));
        send_sample(mk(PH_BAD3, 48'd4600, 1'b1, ST_OK, 6400, ST_OK, 0));
        send_sample(mk(PH_HOLD, 48'd0, 1'b1, ST_OK, -32768, ST_UNAVAIL, -32768));
        send_sample(mk(PH_HOLD, MAX48, 1'b1, ST_OK, 32767, ST_RSVD, 32767));
    endtask

    // Product sensor rules in holding; zero band width and no grace
    task automatic test_product_sensor();
        apply_setting(-5000, 0, 0, 32767, 48'd500, 48'd0, 48'd1000, SENSOR_PRODUCT);
        sample_clock = 48'd5000;
        run_phase    = 1'b1;
        random_run(200, 10, 48'd1000);
    endtask

    // Everything at the top of its range, timestamps near the wrap point
    task automatic test_wide_limits();
        apply_setting(32767, 32767, 32767, 32767, MAX48, MAX48, MAX48, SENSOR_AIR);
        sample_clock = 48'hFFF0_0000_0000;
        random_run(150, 10, 48'h00FF_FFFF_FFFF);
    endtask

    // Tightest limits: one ms of gap, grace and required time
    task automatic test_tight_limits();
        apply_setting(-32768, 100, 0, 32767, 48'd1, 48'd1, 48'd1, SENSOR_PRODUCT);
        sample_clock = TW'({$urandom(), $urandom()}) >> 1;
        random_run(150, 10, 48'd1);
    endtask

    // Band width against floor and ceiling, including both exact edges
    task automatic test_band_limits();
        apply_setting(0, 100, 200, 32767, 48'd1000, 48'd100, 48'd300, SENSOR_AIR);
        random_run(50, 10, 48'd300);
        drain_results();
        write_reg(REG_BAND_FLOOR, 64'd0);
        write_reg(REG_BAND_CEILING, 64'd50);
        random_run(50, 10, 48'd300);
        drain_results();
        write_reg(REG_BAND_CEILING, 64'd100);
        write_reg(REG_BAND_FLOOR, 64'd100);
        random_run(50, 10, 48'd300);
    endtask

    // Zero required time, then zero gap limit
    task automatic test_zero_limits();
        drain_results();
        write_reg(REG_REQUIRED_MS, 64'd0);
        random_run(30, 10, 48'd300);
        drain_results();
        write_reg(REG_REQUIRED_MS, 64'd2000);
        write_reg(REG_MAX_GAP_MS, 64'd0);
        random_run(30, 10, 48'd300);
    endtask

    // Long streams on realistic settings
    task automatic test_long_runs();
        apply_setting(6400, 256, 16, 4096, 48'd2000, 48'd600, 48'd400, SENSOR_AIR);
        sample_clock = 48'd0;
        run_phase    = 1'b0;
        random_run(300, 8, 48'd400);
        apply_setting(2000, 500, 0, 32767, 48'd5000, 48'd1000, 48'd800, SENSOR_PRODUCT);
        random_run(400, 8, 48'd800);
        apply_setting(0, 256, 0, 32767, 48'd1500, 48'd0, 48'd300, SENSOR_AIR);
        random_run(150, 8, 48'd300);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        // Drive every input to a known value before the first edge
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        i_in_valid       = 1'b0;
        i_phase          = PH_PREHEAT;
        i_sample_time_ms = '0;
        i_timing_known   = 1'b0;
        i_air_status     = ST_OK;
        i_air_temp       = '0;
        i_product_status = ST_OK;
        i_product_temp   = '0;
        i_out_stall      = 1'b0;
        stall_tick       = 0;
        in_idle_mode     = 0;
        out_stall_mode   = 0;
        burst_left       = 0;
        mismatch_count   = 0;
        quiet_cycles     = 0;
        reset_released   = 1'b0;
        sample_clock     = '0;
        run_phase        = 1'b0;

        // Register shadow at its reset values
        cfg_target       = '0;
        cfg_band_width   = 15'(BAND_WIDTH_RESET);
        cfg_band_floor   = '0;
        cfg_band_ceiling = 15'd32767;
        cfg_required_ms  = '0;
        cfg_grace_ms     = '0;
        cfg_max_gap_ms   = '0;
        cfg_sensor       = SENSOR_AIR;
        ep_last_phase    = PHASE_PREHEAT;
        drop_episode();

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n        <= 1'b1;
        reset_released  = 1'b1;

        test_reset_values();
        test_dwell_sequence();
        test_product_sensor();
        test_wide_limits();
        test_tight_limits();
        test_band_limits();
        test_zero_limits();
        test_long_runs();

        drain_results();
        repeat (6) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
